@@ rtl/psal_pkg.sv @@
package psal_pkg;

    localparam int SITES     = 16;
    localparam int WAITERS   = 32;
    localparam int SITE_W    = 4;
    localparam int SLOT_W    = 5;
    localparam int QLEN_W    = 6;
    localparam int ALIM_W    = 10;
    localparam int QLIM_W    = 8;
    localparam int TAG_W     = 16;

    localparam logic [2:0] OP_ACQUIRE = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_CANCEL  = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_UPDATE  = 3'd4;

    localparam logic [1:0] OC_GRANTED = 2'd0;
    localparam logic [1:0] OC_QUEUED  = 2'd1;
    localparam logic [1:0] OC_FULL    = 2'd2;
    localparam logic [1:0] OC_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [2:0]        op;
        logic [SITE_W-1:0] site;
        logic [ALIM_W-1:0] active_limit;
        logic [QLIM_W-1:0] queue_limit;
        logic [TAG_W-1:0]  waiter_tag;
    } t_req;

    typedef struct packed {
        logic [SITE_W-1:0] result_site;
        logic [TAG_W-1:0]  result_waiter;
        logic [1:0]        outcome;
        logic              last;
    } t_rsp;

    // Per-site record kept in the site memory.
    typedef struct packed {
        logic [ALIM_W-1:0] active_count;
        logic [ALIM_W-1:0] alim;
        logic [QLIM_W-1:0] qlim;
        logic [QLEN_W-1:0] qlen;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } t_site;

    localparam int SITE_REC_W = $bits(t_site);
    localparam int SLOT_REC_W = TAG_W + SLOT_W;

endpackage

@@ rtl/per_site_admission_limiter.sv @@
// Per-site admission limiter: counting semaphore per site with a bounded
// FIFO of numbered waiters; all sites share one pool of waiter slots.
//
// Input: drive i_req and pulse i_start while o_busy is low; the transaction
// is taken at that edge and o_busy rises the next cycle.
// Output: each result appears on o_rsp for one cycle with o_valid high;
// o_rsp.last marks the final result of a transaction. The receiver has no
// way to stall; results must be taken as they come.
//
// Sequence, from the accepting edge: S_RDSITE fetches the site record,
// S_DECIDE decides. A plain acquire then passes S_PROM, checking for
// promotions, S_OWN, resolving its own outcome (registered onto o_rsp),
// and S_WB, writing back; the next transaction can be taken once S_WB
// returns to idle. A plain release goes from S_DECIDE to S_WB, an unused
// op straight back to idle. Each promotion adds a slot read, then a pop;
// queuing adds S_LINK, which reads, then relinks an existing tail.
// Cancel/timeout searches read, then compare each visited waiter (up to
// 32), and read, then relink around a waiter that is not the head.
//
// Reset: synchronous, active low. A clearing pass over the 16-entry site
// memory runs after reset with o_busy high; the waiter number restarts at
// one and every slot in the pool is free.
module per_site_admission_limiter
    import psal_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_valid,
    output t_rsp o_rsp
);
    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_RDSITE = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_PROM   = 9'b000010000,
        S_WALK   = 9'b000100000,
        S_OWN    = 9'b001000000,
        S_LINK   = 9'b010000000,
        S_WB     = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_site  r_st, n_st;
    logic [TAG_W-1:0]  r_tag, n_tag;       // next waiter number
    logic [TAG_W-1:0]  r_own, n_own;       // this acquire's number
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_prev, n_prev;
    logic [QLEN_W-1:0] r_idx, n_idx;
    logic [SITE_W-1:0] r_clr, n_clr;
    logic [SLOT_W-1:0] r_newslot, n_newslot;
    logic              r_pend, n_pend;     // slot read in flight

    logic               site_we;
    logic [SITE_W-1:0]  site_waddr, site_raddr;
    t_site              site_wdata, site_rdata;
    logic               slot_we;
    logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
    logic [SLOT_REC_W-1:0] slot_wdata, slot_rdata;
    logic [TAG_W-1:0]   slot_rtag;
    logic [SLOT_W-1:0]  slot_rnext;
    logic               alloc, free_en, pool_avail;
    logic [SLOT_W-1:0]  free_slot, pool_slot;
    logic               valid;
    t_rsp               rsp;

    assign slot_rtag  = slot_rdata[SLOT_REC_W-1:SLOT_W];
    assign slot_rnext = slot_rdata[SLOT_W-1:0];

    psal_ram #(.WIDTH(SITE_REC_W), .DEPTH(SITES)) u_site_mem (
        .i_clk(i_clk), .i_we(site_we), .i_waddr(site_waddr), .i_wdata(site_wdata),
        .i_raddr(site_raddr), .o_rdata(site_rdata)
    );

    psal_ram #(.WIDTH(SLOT_REC_W), .DEPTH(WAITERS)) u_slot_mem (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );

    psal_free_pool u_pool (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_alloc(alloc), .i_alloc_slot(r_newslot),
        .i_free(free_en), .i_free_slot(free_slot),
        .o_avail(pool_avail), .o_free_slot(pool_slot)
    );

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_st      = r_st;
        n_tag     = r_tag;
        n_own     = r_own;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_idx     = r_idx;
        n_clr     = r_clr;
        n_newslot = r_newslot;
        n_pend    = 1'b0;
        site_we    = 1'b0;
        site_waddr = r_req.site;
        site_wdata = r_st;
        site_raddr = r_req.site;
        slot_we    = 1'b0;
        slot_waddr = r_cur;
        slot_wdata = '0;
        slot_raddr = r_cur;
        alloc      = 1'b0;
        free_en    = 1'b0;
        free_slot  = r_cur;
        valid      = 1'b0;
        rsp        = '0;
        rsp.result_site = r_req.site;

        unique case (r_state)
            S_CLEAR: begin
                site_we    = 1'b1;
                site_waddr = r_clr;
                site_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == SITE_W'(SITES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                site_raddr = i_req.site;
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_RDSITE;
                end
            end
            S_RDSITE: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_st  = site_rdata;
                n_cur = site_rdata.head;
                n_idx = '0;
                unique case (r_req.op)
                    OP_ACQUIRE, OP_UPDATE: begin
                        n_st.alim = r_req.active_limit;
                        n_st.qlim = r_req.queue_limit;
                        if (r_req.op == OP_ACQUIRE) begin
                            n_own = r_tag;
                            n_tag = r_tag + 1'b1;
                        end
                        n_state = S_PROM;
                    end
                    OP_RELEASE: begin
                        if (site_rdata.active_count > site_rdata.alim) begin
                            n_st.active_count = site_rdata.active_count - 1'b1;
                            n_state = S_WB;
                        end else if (site_rdata.qlen != '0) begin
                            n_state = S_PROM;
                        end else begin
                            if (site_rdata.active_count != '0) begin
                                n_st.active_count = site_rdata.active_count - 1'b1;
                            end
                            n_state = S_WB;
                        end
                    end
                    OP_CANCEL, OP_TIMEOUT: begin
                        n_state = S_WALK;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PROM: begin
                // Pop head: issue read, then consume it.
                if (!r_pend) begin
                    if (r_req.op == OP_RELEASE ||
                        (r_st.active_count < r_st.alim && r_st.qlen != '0)) begin
                        slot_raddr = r_st.head;
                        n_cur      = r_st.head;
                        n_pend     = 1'b1;
                    end else if (r_req.op == OP_ACQUIRE) begin
                        n_state = S_OWN;
                    end else begin
                        n_state = S_WB;
                    end
                end else begin
                    free_en   = 1'b1;
                    valid     = 1'b1;
                    rsp.result_waiter = slot_rtag;
                    rsp.outcome = OC_GRANTED;
                    n_st.head = slot_rnext;
                    n_st.qlen = r_st.qlen - 1'b1;
                    if (r_req.op == OP_RELEASE) begin
                        rsp.last = 1'b1;
                        n_state  = S_WB;
                    end else begin
                        n_st.active_count = r_st.active_count + 1'b1;
                        if (r_req.op == OP_UPDATE &&
                            !(r_st.active_count + 1'b1 < r_st.alim &&
                              r_st.qlen != QLEN_W'(1))) begin
                            rsp.last = 1'b1;
                        end
                    end
                end
            end
            S_OWN: begin
                valid = 1'b1;
                rsp.last = 1'b1;
                rsp.result_waiter = r_own;
                if (r_st.qlen == '0 && r_st.active_count < r_st.alim) begin
                    n_st.active_count = r_st.active_count + 1'b1;
                    rsp.outcome = OC_GRANTED;
                    n_state = S_WB;
                end else if ({2'b00, r_st.qlen} >= r_st.qlim || !pool_avail) begin
                    rsp.outcome = OC_FULL;
                    n_state = S_WB;
                end else begin
                    rsp.outcome = OC_QUEUED;
                    slot_we    = 1'b1;
                    slot_waddr = pool_slot;
                    slot_wdata = {r_own, SLOT_W'(0)};
                    n_newslot  = pool_slot;
                    n_prev     = r_st.tail;
                    if (r_st.qlen == '0) begin
                        n_st.head = pool_slot;
                    end
                    n_st.tail = pool_slot;
                    n_st.qlen = r_st.qlen + 1'b1;
                    n_state   = S_LINK;
                end
            end
            S_LINK: begin
                // Old tail's next is rewritten; read it first to keep its tag.
                if (r_st.qlen == QLEN_W'(1)) begin
                    alloc   = 1'b1;
                    n_state = S_WB;
                end else if (!r_pend) begin
                    slot_raddr = r_prev;
                    n_pend     = 1'b1;
                end else begin
                    alloc      = 1'b1;
                    slot_we    = 1'b1;
                    slot_waddr = r_prev;
                    slot_wdata = {slot_rtag, r_newslot};
                    n_state    = S_WB;
                end
            end
            S_WALK: begin
                if (r_idx == r_st.qlen) begin
                    n_state = S_IDLE;
                end else if (!r_pend) begin
                    slot_raddr = r_cur;
                    n_pend     = 1'b1;
                end else if (slot_rtag == r_req.waiter_tag) begin
                    free_en = 1'b1;
                    if (r_idx == r_st.qlen - 1'b1 && r_idx != '0) begin
                        n_st.tail = r_prev;
                    end
                    n_st.qlen = r_st.qlen - 1'b1;
                    if (r_req.op == OP_TIMEOUT) begin
                        valid = 1'b1;
                        rsp.last = 1'b1;
                        rsp.result_waiter = r_req.waiter_tag;
                        rsp.outcome = OC_TIMEOUT;
                    end
                    if (r_idx == '0) begin
                        n_st.head = slot_rnext;
                    end else begin
                        // Prev's tag must survive: fetch it, then relink.
                        n_newslot = slot_rnext;
                        n_idx     = '1;
                    end
                    n_state = S_WB;
                end else begin
                    n_prev = r_cur;
                    n_cur  = slot_rnext;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_WB: begin
                if (r_idx == '1 && r_state == S_WB && !r_pend &&
                    (r_req.op == OP_CANCEL || r_req.op == OP_TIMEOUT)) begin
                    // relink prev.next around the removed slot
                    slot_raddr = r_prev;
                    n_pend     = 1'b1;
                end else if (r_pend) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_prev;
                    slot_wdata = {slot_rtag, r_newslot};
                    n_idx      = '0;
                end else begin
                    site_we = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_tag   <= TAG_W'(1);
            r_pend  <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_tag   <= n_tag;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
            o_valid <= valid;
        end
        r_req     <= n_req;
        r_st      <= n_st;
        r_own     <= n_own;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_newslot <= n_newslot;
        o_rsp     <= rsp;
    end

    assign o_busy = (r_state != S_IDLE);

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> o_busy) else $error("start not taken");
    a_site_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        site_we |=> !o_busy || r_state == S_CLEAR) else $error("write-back not final");
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !valid) else $error("result while idle");
endmodule

@@ rtl/psal_ram.sv @@
module psal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/psal_free_pool.sv @@
module psal_free_pool
    import psal_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_alloc,
    input  logic [SLOT_W-1:0] i_alloc_slot,
    input  logic              i_free,
    input  logic [SLOT_W-1:0] i_free_slot,
    output logic              o_avail,
    output logic [SLOT_W-1:0] o_free_slot
);
    logic [WAITERS-1:0] r_live;

    // Lowest free slot, same order as a linear search.
    always_comb begin
        o_avail     = 1'b0;
        o_free_slot = '0;
        for (int i = WAITERS - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                o_avail     = 1'b1;
                o_free_slot = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else begin
            if (i_free) begin
                r_live[i_free_slot] <= 1'b0;
            end
            if (i_alloc) begin
                r_live[i_alloc_slot] <= 1'b1;
            end
        end
    end

    a_alloc_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_alloc |-> !r_live[i_alloc_slot]) else $error("alloc of live slot");
    a_free_live_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_free |-> r_live[i_free_slot]) else $error("free of idle slot");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_alloc && i_free)) else $error("alloc and free together");
endmodule
